// ===== hw/rtl/wfd_pkg.sv =====
// Shared types, constants and helpers of the frame decoder.
package wfd_pkg;

  // Width of the stored payload length and payload index (8 to 32)
  localparam int LENGTH_WIDTH = 16;
  localparam int LIMIT_WIDTH  = 16;
  localparam int CMP_WIDTH    = (LENGTH_WIDTH > LIMIT_WIDTH) ? LENGTH_WIDTH : LIMIT_WIDTH;

  // Configuration port
  localparam int CFG_ADDR_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 32;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LIMIT_ADDR = '0;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = '1;

  // Header field codes
  localparam logic [6:0] LEN_CODE_16  = 7'd126;
  localparam logic [6:0] LEN_CODE_64  = 7'd127;
  localparam logic [3:0] OPC_MAX_DATA = 4'h2;
  localparam logic [3:0] OPC_CLOSE    = 4'h8;
  localparam logic [7:0] EXT64_TOP_MASK = 8'h7f;

  // Header byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  // Frame status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CLOSE   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT16   = 6'b000100,
    PH_EXT64   = 6'b001000,
    PH_KEY     = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       frame_end;
    logic [1:0] status;
    logic [3:0] opcode;
    logic       fin;
  } result_t;

  // Status a completed header gives for its opcode
  function automatic logic [1:0] opcode_status(input logic [3:0] opcode);
    logic [1:0] st;
    if (opcode <= OPC_MAX_DATA) begin
      st = ST_OK;
    end else if (opcode == OPC_CLOSE) begin
      st = ST_CLOSE;
    end else begin
      st = ST_UNKNOWN;
    end
    return st;
  endfunction

endpackage

// ===== hw/rtl/wfd_cfg.sv =====
// APB-style register file holding the extended length limit.
module wfd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfd_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [wfd_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [wfd_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready,
  output logic [wfd_pkg::LIMIT_WIDTH-1:0]     length_limit
);

  logic wr_en;

  // Decode a write request to the limit register
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == wfd_pkg::CFG_LIMIT_ADDR);

  // Take the limit on the access cycle of a write request
  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit <= wfd_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      length_limit <= pwdata[wfd_pkg::LIMIT_WIDTH-1:0];
    end
  end

  assign prdata = wfd_pkg::CFG_DATA_WIDTH'(length_limit);

endmodule

// ===== hw/rtl/wfd_deframe.sv =====
// Frame header parser, payload unmasking and frame state registers.
module wfd_deframe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [7:0]                       byte_data,
  input  logic                             byte_last,
  input  logic [wfd_pkg::LIMIT_WIDTH-1:0]  length_limit,
  output wfd_pkg::result_t                 res
);

  localparam int LW = wfd_pkg::LENGTH_WIDTH;

  wfd_pkg::phase_t phase, phase_next;
  logic [3:0]      header_count, header_count_next;
  logic [3:0]      frame_opcode, frame_opcode_next;
  logic            fin_flag, fin_flag_next;
  logic            masked_flag, masked_flag_next;
  logic [LW-1:0]   payload_length, payload_length_next;
  logic            length_overflow, length_overflow_next;
  logic [3:0][7:0] mask_key, mask_key_next;
  logic [LW-1:0]   payload_index, payload_index_next;
  logic [1:0]      frame_status, frame_status_next;

  logic [7:0]      ext_byte;
  logic [LW+7:0]   shifted;
  logic            pushed_ovf;
  logic [LW-1:0]   pushed_len;
  logic [3:0]      hc_inc;
  logic [1:0]      hdr_status;
  logic            limit_reject;
  logic [7:0]      key_byte;
  logic            pv;
  logic [7:0]      pb;
  logic [1:0]      end_status;

  // Shift one byte into the declared length
  always_comb begin
    ext_byte = byte_data;
    if (phase == wfd_pkg::PH_EXT64 && header_count == '0) begin
      ext_byte = byte_data & wfd_pkg::EXT64_TOP_MASK;
    end
    shifted      = {payload_length, ext_byte};
    pushed_ovf   = length_overflow | (|shifted[LW+7:LW]);
    pushed_len   = shifted[LW-1:0];
    hc_inc       = header_count + 4'd1;
    hdr_status   = (frame_status == wfd_pkg::ST_UNKNOWN) ? wfd_pkg::ST_UNKNOWN
                 : wfd_pkg::opcode_status(frame_opcode);
    limit_reject = pushed_ovf ||
                   (wfd_pkg::CMP_WIDTH'(pushed_len) >= wfd_pkg::CMP_WIDTH'(length_limit));
    key_byte     = masked_flag ? mask_key[2'd3 - payload_index[1:0]] : 8'h00;
  end

  // Advance the frame state by one byte
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    frame_opcode_next    = frame_opcode;
    fin_flag_next        = fin_flag;
    masked_flag_next     = masked_flag;
    payload_length_next  = payload_length;
    length_overflow_next = length_overflow;
    mask_key_next        = mask_key;
    payload_index_next   = payload_index;
    frame_status_next    = frame_status;
    pv                   = 1'b0;
    pb                   = 8'h00;
    case (phase)
      wfd_pkg::PH_HDR0: begin
        frame_opcode_next    = byte_data[3:0];
        fin_flag_next        = byte_data[7];
        masked_flag_next     = 1'b0;
        payload_length_next  = '0;
        length_overflow_next = 1'b0;
        mask_key_next        = '0;
        payload_index_next   = '0;
        frame_status_next    = wfd_pkg::ST_OK;
        header_count_next    = '0;
        phase_next           = wfd_pkg::PH_HDR1;
      end
      wfd_pkg::PH_HDR1: begin
        masked_flag_next  = byte_data[7];
        header_count_next = '0;
        if (byte_data[6:0] == wfd_pkg::LEN_CODE_16) begin
          phase_next = wfd_pkg::PH_EXT16;
        end else if (byte_data[6:0] == wfd_pkg::LEN_CODE_64) begin
          phase_next = wfd_pkg::PH_EXT64;
        end else begin
          payload_length_next = LW'(byte_data[6:0]);
          frame_status_next   = hdr_status;
          phase_next          = byte_data[7] ? wfd_pkg::PH_KEY : wfd_pkg::PH_PAYLOAD;
        end
      end
      wfd_pkg::PH_EXT16: begin
        payload_length_next  = pushed_len;
        length_overflow_next = pushed_ovf;
        header_count_next    = hc_inc;
        if (hc_inc >= wfd_pkg::EXT16_BYTES) begin
          frame_status_next = pushed_ovf ? wfd_pkg::ST_UNKNOWN : hdr_status;
          header_count_next = '0;
          phase_next        = masked_flag ? wfd_pkg::PH_KEY : wfd_pkg::PH_PAYLOAD;
        end
      end
      wfd_pkg::PH_EXT64: begin
        payload_length_next  = pushed_len;
        length_overflow_next = pushed_ovf;
        header_count_next    = hc_inc;
        if (hc_inc >= wfd_pkg::EXT64_BYTES) begin
          frame_status_next = limit_reject ? wfd_pkg::ST_UNKNOWN : hdr_status;
          header_count_next = '0;
          phase_next        = masked_flag ? wfd_pkg::PH_KEY : wfd_pkg::PH_PAYLOAD;
        end
      end
      wfd_pkg::PH_KEY: begin
        mask_key_next     = {mask_key[2:0], byte_data};
        header_count_next = hc_inc;
        if (hc_inc >= wfd_pkg::KEY_BYTES) begin
          header_count_next = '0;
          phase_next        = wfd_pkg::PH_PAYLOAD;
        end
      end
      wfd_pkg::PH_PAYLOAD: begin
        // Drop bytes beyond the declared length
        if (payload_index < payload_length) begin
          if (frame_status == wfd_pkg::ST_OK) begin
            pv = 1'b1;
            pb = byte_data ^ key_byte;
          end
          payload_index_next = payload_index + LW'(1);
        end
      end
      default: begin
        phase_next = wfd_pkg::PH_HDR0;
      end
    endcase

    // Close the packet: an end before the payload is malformed
    end_status = wfd_pkg::ST_OK;
    if (byte_last) begin
      end_status = (phase_next == wfd_pkg::PH_PAYLOAD) ? frame_status_next
                 : wfd_pkg::ST_UNKNOWN;
      phase_next = wfd_pkg::PH_HDR0;
    end
  end

  // Build the result for this byte
  always_comb begin
    res.emit          = pv | byte_last;
    res.payload_byte  = pb;
    res.payload_valid = pv;
    res.frame_end     = byte_last;
    res.status        = end_status;
    res.opcode        = frame_opcode_next;
    res.fin           = fin_flag_next;
  end

  // Hold the frame state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= wfd_pkg::PH_HDR0;
      header_count    <= '0;
      frame_opcode    <= '0;
      fin_flag        <= 1'b0;
      masked_flag     <= 1'b0;
      payload_length  <= '0;
      length_overflow <= 1'b0;
      mask_key        <= '0;
      payload_index   <= '0;
      frame_status    <= wfd_pkg::ST_OK;
    end else if (step) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      frame_opcode    <= frame_opcode_next;
      fin_flag        <= fin_flag_next;
      masked_flag     <= masked_flag_next;
      payload_length  <= payload_length_next;
      length_overflow <= length_overflow_next;
      mask_key        <= mask_key_next;
      payload_index   <= payload_index_next;
      frame_status    <= frame_status_next;
    end
  end

  // Payload bytes only leave a good frame in its payload phase
  a_pv_in_payload: assert property (@(posedge clk) disable iff (rst)
    step && res.payload_valid |-> phase == wfd_pkg::PH_PAYLOAD &&
    frame_status == wfd_pkg::ST_OK)
    else $error("payload byte outside a good payload phase");

  // The payload index never runs past the declared length
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    phase == wfd_pkg::PH_PAYLOAD |-> payload_index <= payload_length)
    else $error("payload index beyond declared length");

  // The header byte counter stays within the longest header field
  a_hc_bound: assert property (@(posedge clk) disable iff (rst)
    header_count < wfd_pkg::EXT64_BYTES)
    else $error("header byte counter out of range");

endmodule

// ===== hw/rtl/wfd_out_reg.sv =====
// Result register between the parser and the result channel.
module wfd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wfd_pkg::result_t res,
  input  logic             result_stall,
  output logic             result_valid,
  output logic             ready,
  output logic [7:0]       payload_byte,
  output logic             payload_valid,
  output logic             frame_end,
  output logic [1:0]       status,
  output logic [3:0]       opcode_out,
  output logic             is_final
);

  // Free when empty or when the held request is being taken
  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load && res.emit;
    end
  end

  // Hold the payload while stalled
  always_ff @(posedge clk) begin
    if (ready) begin
      payload_byte  <= res.payload_byte;
      payload_valid <= res.payload_valid;
      frame_end     <= res.frame_end;
      status        <= res.status;
      opcode_out    <= res.opcode;
      is_final      <= res.fin;
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_decoder_core.sv =====
// Top level of the frame decoder: input register, parser and result register.
//
// Bytes of a received packet arrive on the byte channel (byte_valid, byte_stall,
// byte_in, packet_end); packet_end marks the last byte, one frame per packet.
// Results leave on the result channel (result_valid, result_stall): a request
// goes out for each unmasked payload byte of a data frame and one at packet
// end carrying frame_end and status (ok, close, unknown), or both at once.
// Header bytes and dropped bytes give no request.
// A byte is registered in the input register when accepted and parsed from
// there once the result register can take its outcome, which registers its
// request. One byte per cycle is taken while the receiver does not stall; the
// rate is set by the single parse step between the input and result registers.
// When the receiver stalls, the held request stays, the parser pauses and the
// input register holds, so byte_stall rises only when both registers are full
// and the receiver stalls.
// The length limit for the 64-bit length form is written at address 0 of the
// APB-style port and reads back there; reset sets it to 65535.
// Reset (synchronous, rst high) empties both registers and sets the parser to
// expect the first header byte of a new frame.
module websocket_frame_decoder_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                byte_valid,
  output logic                                byte_stall,
  input  logic [7:0]                          byte_in,
  input  logic                                packet_end,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [7:0]                          payload_byte,
  output logic                                payload_valid,
  output logic                                frame_end,
  output logic [1:0]                          status,
  output logic [3:0]                          opcode_out,
  output logic                                is_final,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [wfd_pkg::CFG_ADDR_WIDTH-1:0]  paddr,
  input  logic [wfd_pkg::CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [wfd_pkg::CFG_DATA_WIDTH-1:0]  prdata,
  output logic                                pready
);

  logic                            in_full;
  logic [7:0]                      in_byte;
  logic                            in_last;
  logic                            out_ready;
  logic                            step;
  logic [wfd_pkg::LIMIT_WIDTH-1:0] length_limit;
  wfd_pkg::result_t                res;

  wfd_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .length_limit (length_limit)
  );

  // Parse the held byte whenever the result register can take its outcome
  assign step       = in_full && out_ready;
  assign byte_stall = in_full && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) begin
      in_byte <= byte_in;
      in_last <= packet_end;
    end
  end

  wfd_deframe u_deframe (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .byte_data    (in_byte),
    .byte_last    (in_last),
    .length_limit (length_limit),
    .res          (res)
  );

  wfd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .res           (res),
    .result_stall  (result_stall),
    .result_valid  (result_valid),
    .ready         (out_ready),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .frame_end     (frame_end),
    .status        (status),
    .opcode_out    (opcode_out),
    .is_final      (is_final)
  );

  // A parsed byte with a result always lands in the result register
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    step && res.emit |=> result_valid)
    else $error("parsed result lost");

  // Status is only non-zero on the packet-end request
  a_status_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !frame_end |-> status == wfd_pkg::ST_OK)
    else $error("status set without frame end");

  // A request always carries a payload byte or a frame end
  a_req_content: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> payload_valid || frame_end)
    else $error("empty result request");

endmodule
